>>> hdl/plmi_pkg.sv
// Package for the piecewise-linear map interpolation unit.
// Shared types, codes and defaults; no dependencies.
package plmi_pkg;
    localparam int MAX_POINTS_DEF = 16;

    localparam logic [1:0] FN_INSERT  = 2'd0;
    localparam logic [1:0] FN_CLEAR   = 2'd1;
    localparam logic [1:0] FN_FORWARD = 2'd2;
    localparam logic [1:0] FN_INVERSE = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic CFG_FACTOR  = 1'b0;
    localparam logic CFG_REFLECT = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic               used_factor;
    } t_rsp;

    // One table entry as it moves along the cell chain.
    typedef struct packed {
        logic               vld;
        logic signed [31:0] key;
        logic signed [31:0] val;
    } t_pt;
endpackage

>>> hdl/plmi_if.sv
// Valid/ready channel carrying one payload of type T.
// Uses no package directly; the payload type is given by the instance.
interface plmi_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/piecewise_linear_map_interp_unit.sv
// Top level of the piecewise-linear map interpolation unit.
// Depends on plmi_pkg, plmi_if, plmi_cell and plmi_muldiv.
//
//  channel  | dir | payload
//  ---------+-----+----------------------------------------
//  i_req    | in  | func, in_x, in_y
//  o_rsp    | out | result_value, status, used_factor
//  cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_wdata
//
// One request at a time. Insert passes through S_INS and clear goes straight to
// S_OUT; a lookup walks the chain in S_SCAN and, when it interpolates, waits in
// S_WAIT for the serial multiply/divide unit. Results sit in an output
// register; the next request is taken once that register is free.
// Reset empties the table and clears the state, count, configuration and output-valid registers.
module piecewise_linear_map_interp_unit #(
    parameter int MAX_POINTS = plmi_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    plmi_if.sink        i_req,
    plmi_if.source      o_rsp
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_INS, S_SCAN, S_CALC, S_WAIT, S_FIN, S_OUT}
        t_state;

    t_state r_state;
    logic signed [31:0] r_factor;
    logic               r_reflect;
    plmi_pkg::t_req     r_req;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_idx;
    plmi_pkg::t_pt      r_left, r_right, r_lastp;
    logic               r_rfound;
    logic               r_neg;
    logic signed [33:0] r_v;
    logic signed [66:0] r_res;
    logic               r_used;
    logic [1:0]         r_status;
    logic signed [31:0] r_out;
    logic               r_ovld;
    logic               r_mstart;
    logic               r_msign;
    logic signed [34:0] r_base;
    logic               r_inv;

    plmi_pkg::t_pt w_pt [MAX_POINTS];
    logic [MAX_POINTS-1:0] w_ins, w_shift;
    logic [MAX_POINTS-1:0] w_lt, w_eq;
    plmi_pkg::t_pt w_new;
    logic w_do_ins;
    logic w_done;
    logic [62:0] w_q;
    logic [34:0] r_ma, r_mb, r_md;
    plmi_pkg::t_pt w_cur;
    logic signed [33:0] w_cmp;
    logic w_hit;
    logic signed [66:0] n_res;

    // insert decision over the chain: each cell compares its own key
    always_comb begin
        w_new.vld = 1'b1;
        w_new.key = r_req.in_x;
        w_new.val = r_req.in_y;
        for (int i = 0; i < MAX_POINTS; i++) begin
            w_lt[i] = w_pt[i].vld && (w_pt[i].key < r_req.in_x);
            w_eq[i] = w_pt[i].vld && (w_pt[i].key == r_req.in_x);
        end
        w_do_ins = (r_state == S_INS) && (|w_eq || r_cnt < CW'(MAX_POINTS));
        for (int i = 0; i < MAX_POINTS; i++) begin
            if (|w_eq) begin
                w_ins[i]   = w_do_ins && w_eq[i];
                w_shift[i] = 1'b0;
            end else begin
                w_ins[i]   = w_do_ins && !w_lt[i] && (i == 0 || w_lt[(i == 0) ? 0 : i-1]
                             || i == 0);
                w_shift[i] = w_do_ins && !w_lt[i] && !w_ins[i];
            end
        end
    end

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        plmi_pkg::t_pt w_l;
        if (g == 0) begin : g_first
            assign w_l = '0;
        end else begin : g_rest
            assign w_l = w_pt[g-1];
        end
        plmi_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_clear(r_state == S_IDLE && i_req.valid && i_req.ready &&
                     i_req.data.func == plmi_pkg::FN_CLEAR),
            .i_ins  (w_ins[g]),
            .i_shift(w_shift[g]),
            .i_left (w_l),
            .i_new  (w_new),
            .o_pt   (w_pt[g])
        );
    end

    plmi_muldiv u_md (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_mstart),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .i_d    (r_md),
        .o_done (w_done),
        .o_q    (w_q)
    );

    assign w_cur = w_pt[r_idx[IW-1:0]];
    assign w_cmp = r_inv ? 34'(w_cur.val) : 34'(w_cur.key);
    assign w_hit = r_inv ? (w_cmp < r_v) : (w_cmp <= r_v);

    assign i_req.ready = (r_state == S_IDLE) && !r_ovld;
    assign o_rsp.valid = r_ovld;
    assign o_rsp.data.result_value = r_out;
    assign o_rsp.data.status = r_status;
    assign o_rsp.data.used_factor = r_used;

    always_comb begin
        n_res = r_res;
        if (r_neg) n_res = -r_res;
    end

    always_ff @(posedge i_clk) begin
        r_mstart <= 1'b0;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_factor  <= '0;
            r_reflect <= 1'b0;
            r_cnt     <= '0;
            r_ovld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == plmi_pkg::CFG_FACTOR) r_factor <= i_cfg_wdata;
                else r_reflect <= i_cfg_wdata[0];
            end
            if (o_rsp.valid && o_rsp.ready) r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req    <= i_req.data;
                        r_status <= plmi_pkg::ST_OK;
                        r_used   <= 1'b0;
                        r_res    <= '0;
                        r_neg    <= 1'b0;
                        r_inv    <= (i_req.data.func == plmi_pkg::FN_INVERSE);
                        case (i_req.data.func)
                            plmi_pkg::FN_INSERT: r_state <= S_INS;
                            plmi_pkg::FN_CLEAR: begin
                                r_cnt   <= '0;
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_used <= (r_cnt == '0);
                                r_state <= S_SCAN;
                                r_idx  <= r_cnt;
                                r_rfound <= 1'b0;
                                r_left <= '0;
                                if (i_req.data.func == plmi_pkg::FN_INVERSE) begin
                                    r_v   <= (i_req.data.in_y < 0) ? -34'(i_req.data.in_y)
                                             : 34'(i_req.data.in_y);
                                    r_neg <= i_req.data.in_y < 0;
                                    if (i_req.data.in_y == 0 ||
                                        (i_req.data.in_y < 0 && !r_reflect))
                                        r_state <= S_FIN;
                                end else begin
                                    r_v   <= (i_req.data.in_x < 0) ? -34'(i_req.data.in_x)
                                             : 34'(i_req.data.in_x);
                                    r_neg <= i_req.data.in_x < 0;
                                    if (i_req.data.in_x == 0 ||
                                        (i_req.data.in_x < 0 && !r_reflect))
                                        r_state <= S_FIN;
                                end
                            end
                        endcase
                    end
                end
                S_INS: begin
                    if (!(|w_eq)) begin
                        if (r_cnt < CW'(MAX_POINTS)) r_cnt <= r_cnt + CW'(1);
                        else r_status <= plmi_pkg::ST_FULL;
                    end
                    r_state <= S_OUT;
                end
                S_SCAN: begin
                    // walk down from the last point; r_idx == count means "past end"
                    if (r_cnt == '0) begin
                        r_res   <= 67'(($signed({1'b0, r_v}) * r_factor) >>> 16);
                        r_state <= S_FIN;
                    end else if (r_idx == r_cnt) begin
                        r_lastp <= w_pt[IW'(r_cnt - CW'(1))];
                        r_idx   <= r_cnt - CW'(1);
                        if (r_inv ? (r_v >= 34'(w_pt[IW'(r_cnt - CW'(1))].val))
                                  : (r_v >= 34'(w_pt[IW'(r_cnt - CW'(1))].key))) begin
                            r_res   <= r_inv ? 67'(w_pt[IW'(r_cnt - CW'(1))].key)
                                             : 67'(w_pt[IW'(r_cnt - CW'(1))].val);
                            r_state <= S_FIN;
                        end
                    end else begin
                        if (w_hit) begin
                            r_left  <= w_cur;
                            r_state <= S_CALC;
                        end else begin
                            r_right <= w_cur;
                            if (r_idx == '0) begin
                                r_left  <= '0;
                                r_state <= S_CALC;
                            end else begin
                                r_idx <= r_idx - CW'(1);
                            end
                        end
                        if (!r_rfound) begin
                            r_right <= w_cur;
                            r_rfound <= 1'b1;
                        end
                        if (w_hit && !r_rfound) r_right <= r_lastp;
                        if (!w_hit) r_rfound <= 1'b1;
                    end
                end
                S_CALC: begin
                    if (35'(r_right.key) - 35'(r_left.key) <= 0) begin
                        r_res   <= '0;
                        r_state <= S_FIN;
                    end else if (r_inv && r_right.val == r_left.val) begin
                        r_res   <= 67'(r_left.key);
                        r_state <= S_FIN;
                    end else begin
                        if (r_inv) begin
                            r_ma    <= 35'(r_v) - 35'(r_left.val);
                            r_mb    <= 35'(r_right.key) - 35'(r_left.key);
                            r_md    <= (r_right.val > r_left.val) ?
                                       35'(r_right.val) - 35'(r_left.val) :
                                       35'(r_left.val) - 35'(r_right.val);
                            r_msign <= r_right.val < r_left.val;
                            r_base  <= 35'(r_left.key);
                        end else begin
                            r_ma    <= 35'(r_v) - 35'(r_left.key);
                            r_mb    <= (r_right.val >= r_left.val) ?
                                       35'(r_right.val) - 35'(r_left.val) :
                                       35'(r_left.val) - 35'(r_right.val);
                            r_md    <= 35'(r_right.key) - 35'(r_left.key);
                            r_msign <= r_right.val < r_left.val;
                            r_base  <= 35'(r_left.val);
                        end
                        r_mstart <= 1'b1;
                        r_state  <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_res   <= 67'(r_base) + (r_msign ? -67'(w_q) : 67'(w_q));
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (n_res > 67'sd2147483647) begin
                        r_out    <= 32'h7FFFFFFF;
                        r_status <= plmi_pkg::ST_SAT;
                    end else if (n_res < -67'sd2147483648) begin
                        r_out    <= 32'h80000000;
                        r_status <= plmi_pkg::ST_SAT;
                    end else begin
                        r_out <= n_res[31:0];
                    end
                    r_ovld  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_OUT: begin
                    r_out   <= '0;
                    r_ovld  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/plmi_cell.sv
// One cell of the sorted breakpoint chain: holds one point, shifts right on insert.
// Depends on plmi_pkg.
module plmi_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_ins,
    input  logic            i_shift,
    input  plmi_pkg::t_pt   i_left,
    input  plmi_pkg::t_pt   i_new,
    output plmi_pkg::t_pt   o_pt
);
    plmi_pkg::t_pt r_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pt.vld <= 1'b0;
        end else if (i_ins) begin
            r_pt <= i_new;
        end else if (i_shift) begin
            r_pt <= i_left;
        end
        if (i_rst_n && !i_clear && !i_ins && i_shift) begin
            r_pt.key <= i_left.key;
        end
    end

    assign o_pt = r_pt;
endmodule

>>> hdl/plmi_muldiv.sv
// Serial trunc(a*b/d) on unsigned operands, capped at 2^62; one quotient bit per cycle.
// No dependencies; standalone arithmetic unit.
module plmi_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [34:0]        i_a,
    input  logic [34:0]        i_b,
    input  logic [34:0]        i_d,
    output logic               o_done,
    output logic [62:0]        o_q
);
    logic [69:0]  r_num;
    logic [34:0]  r_d;
    logic [35:0]  r_rem;
    logic [62:0]  r_q;
    logic [6:0]   r_cnt;
    logic         r_busy;
    logic         r_mul;
    logic [69:0]  r_pa;
    logic [34:0]  r_pb;
    logic [5:0]   r_mcnt;
    logic [35:0]  n_rem;
    logic         n_qb;
    logic [63:0]  n_q;

    always_comb begin
        n_rem = {r_rem[34:0], r_num[69]};
        n_qb  = 1'b0;
        if (n_rem >= {1'b0, r_d}) begin
            n_rem = n_rem - {1'b0, r_d};
            n_qb  = 1'b1;
        end
        n_q = {r_q, n_qb};
        if (r_q >= 63'(64'd1 << 62)) n_q = 64'd1 << 62;
        else if (n_q > (64'd1 << 62)) n_q = 64'd1 << 62;
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
        end else if (i_start) begin
            // shift-add product first, then restoring division
            r_mul  <= 1'b1;
            r_pa   <= {35'd0, i_a};
            r_pb   <= i_b;
            r_num  <= '0;
            r_d    <= i_d;
            r_mcnt <= 6'd0;
        end else if (r_mul) begin
            if (r_pb[0]) r_num <= r_num + r_pa;
            r_pa   <= r_pa << 1;
            r_pb   <= r_pb >> 1;
            r_mcnt <= r_mcnt + 6'd1;
            if (r_mcnt == 6'd34) begin
                r_mul  <= 1'b0;
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= 7'd0;
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q[62:0];
            r_num <= r_num << 1;
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'd69) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    assign o_q = r_q;
endmodule

>>> tb/piecewise_linear_map_interp_unit_tb.sv
// Testbench for the piecewise-linear map interpolation unit.
// Depends on plmi_pkg, plmi_if and the unit's RTL; predicts every response and compares.
module piecewise_linear_map_interp_unit_tb;
    import plmi_pkg::*;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam longint TWO62 = 64'sd1 <<< 62;
    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    plmi_if #(.T(t_req)) req_ch ();
    plmi_if #(.T(t_rsp)) rsp_ch ();

    piecewise_linear_map_interp_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    // predictor state
    logic signed [31:0] tbl_key [NPTS];
    logic signed [31:0] tbl_val [NPTS];
    int                 tbl_cnt;
    logic signed [31:0] gain;
    logic               mirror;

    t_rsp rsp_queue [$];
    int   err_cnt;
    int   cyc;
    int   burst_left;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("[piecewise_linear_map_interp_unit] ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cyc);
        err_cnt++;
    endtask

    // receiver: stalls on its own pattern, checks each response
    logic [3:0] stall_lfsr;
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            stall_lfsr <= 4'h9;
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (rsp_queue.size() == 0) begin
                    report("unexpected response", rsp_ch.data.result_value, 0);
                end else begin
                    want = rsp_queue.pop_front();
                    if (rsp_ch.data.result_value !== want.result_value)
                        report("result_value", rsp_ch.data.result_value, want.result_value);
                    if (rsp_ch.data.status !== want.status)
                        report("status", rsp_ch.data.status, want.status);
                    if (rsp_ch.data.used_factor !== want.used_factor)
                        report("used_factor", rsp_ch.data.used_factor, want.used_factor);
                end
            end
            stall_lfsr <= {stall_lfsr[2:0], stall_lfsr[3] ^ stall_lfsr[2]};
            // long ready stretches mixed with stalls
            rsp_ch.ready <= (cyc % 512 < 128) ? 1'b1 : (stall_lfsr[0] | stall_lfsr[1]);
        end
    end

    function automatic longint abs64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // sign * trunc(|a|*|b|/|d|), magnitude capped at 2^62
    function automatic longint scaled_ratio(input longint a, input longint b, input longint d);
        logic        neg;
        logic [127:0] prod;
        logic [127:0] quo;
        neg = (a < 0) ^ (b < 0) ^ (d < 0);
        prod = 128'(abs64(a)) * 128'(abs64(b));
        quo = prod / 128'(abs64(d));
        if (quo > 128'(TWO62)) quo = 128'(TWO62);
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic longint gain_product(input longint v);
        longint p;
        p = v * longint'(gain);
        return p >>> 16;
    endfunction

    function automatic longint map_positive(input longint v, input logic inv);
        longint lk, lv, rk, rv, run, rise;
        int     fnd, k;
        lk = 0;
        lv = 0;
        fnd = -1;
        if (tbl_cnt == 0) return gain_product(v);
        if (!inv && v >= tbl_key[tbl_cnt-1]) return tbl_val[tbl_cnt-1];
        if (inv && v >= tbl_val[tbl_cnt-1]) return tbl_key[tbl_cnt-1];
        for (int i = tbl_cnt - 1; i >= 0 && fnd < 0; i--)
            if (inv ? (tbl_val[i] < v) : (tbl_key[i] <= v)) fnd = i;
        if (fnd >= 0) begin
            lk = tbl_key[fnd];
            lv = tbl_val[fnd];
            k = fnd + 1;
        end else begin
            k = 0;
        end
        rk = tbl_key[k];
        rv = tbl_val[k];
        run = rk - lk;
        if (run <= 0) return 0;
        rise = rv - lv;
        if (!inv) return lv + scaled_ratio(v - lk, rise, run);
        if (rise == 0) return lk;
        return lk + scaled_ratio(v - lv, run, rise);
    endfunction

    function automatic t_rsp predict_response(input t_req rq);
        t_rsp   r;
        longint op, res;
        int     pos;
        logic   inv;
        r = '0;
        res = 0;
        case (rq.func)
            FN_INSERT: begin
                pos = 0;
                while (pos < tbl_cnt && tbl_key[pos] < rq.in_x) pos++;
                if (pos < tbl_cnt && tbl_key[pos] == rq.in_x) begin
                    tbl_val[pos] = rq.in_y;
                end else if (tbl_cnt >= NPTS) begin
                    r.status = ST_FULL;
                end else begin
                    for (int j = tbl_cnt; j > pos; j--) begin
                        tbl_key[j] = tbl_key[j-1];
                        tbl_val[j] = tbl_val[j-1];
                    end
                    tbl_key[pos] = rq.in_x;
                    tbl_val[pos] = rq.in_y;
                    tbl_cnt++;
                end
            end
            FN_CLEAR: tbl_cnt = 0;
            default: begin
                inv = (rq.func == FN_INVERSE);
                op = inv ? longint'(rq.in_y) : longint'(rq.in_x);
                r.used_factor = (tbl_cnt == 0);
                if (op > 0) res = map_positive(op, inv);
                else if (op < 0 && mirror) res = -map_positive(-op, inv);
                if (res > 64'sd2147483647) begin
                    res = 64'sd2147483647;
                    r.status = ST_SAT;
                end else if (res < -64'sd2147483648) begin
                    res = -64'sd2147483648;
                    r.status = ST_SAT;
                end
            end
        endcase
        r.result_value = res[31:0];
        return r;
    endfunction

    // send one request in bursts with random gaps
    task automatic send_request(input logic [1:0] fn, input logic [31:0] x, input logic [31:0] y);
        t_req rq;
        rq.func = fn;
        rq.in_x = x;
        rq.in_y = y;
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.data <= rq;
        do @(posedge i_clk); while (!req_ch.ready);
        rsp_queue.push_back(predict_response(rq));
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (rsp_queue.size() != 0) @(posedge i_clk);
        // an output register may still hold nothing in flight; allow the unit to settle
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FACTOR) gain = val;
        else mirror = val[0];
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 20)) - 10);
            3: return $urandom_range(0, 32'h000f_ffff);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_table();
        write_reg(CFG_FACTOR, 32'h0002_8000);
        write_reg(CFG_REFLECT, 1'b1);
        send_request(FN_FORWARD, 32'h0001_0000, 0);
        send_request(FN_INVERSE, 0, 32'hffff_0001);
        send_request(FN_FORWARD, 0, 0);
        send_request(FN_FORWARD, 32'h7fff_ffff, 0);
        send_request(FN_FORWARD, 32'h8000_0000, 0);
        drain_responses();
        write_reg(CFG_FACTOR, 32'h8000_0000);
        write_reg(CFG_REFLECT, 1'b0);
        send_request(FN_FORWARD, 32'h0000_0003, 0);
        send_request(FN_INVERSE, 0, 32'h8000_0000);
        send_request(FN_FORWARD, 32'h7fff_ffff, 0);
        drain_responses();
        write_reg(CFG_FACTOR, 32'h7fff_ffff);
        write_reg(CFG_REFLECT, 1'b1);
    endtask

    task automatic test_table_edges();
        send_request(FN_INSERT, 32'h0001_0000, 32'h0002_0000);
        send_request(FN_INSERT, 32'h0004_0000, 32'h0002_0000);
        send_request(FN_INSERT, 32'h0001_0000, 32'h0003_0000);
        send_request(FN_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_request(FN_INSERT, 32'hffff_0000, 32'h7fff_ffff);
        send_request(FN_FORWARD, 32'h0000_8000, 0);
        send_request(FN_FORWARD, 32'h0002_0000, 0);
        send_request(FN_INVERSE, 0, 32'h0002_8000);
        send_request(FN_INVERSE, 0, 32'h8000_0000);
        send_request(FN_FORWARD, 32'h8000_0000, 0);
        send_request(FN_CLEAR, 0, 0);
        for (int i = 1; i <= NPTS + 2; i++)
            send_request(FN_INSERT, 32'(i * 32'h0001_0000), 32'(i * i * 32'h0000_4000));
        send_request(FN_INSERT, 32'h0003_0000, 32'h0000_0000);
        send_request(FN_INVERSE, 0, 32'h0000_6000);
        drain_responses();
    endtask

    task automatic test_random(input int count);
        logic [1:0] fn;
        for (int n = 0; n < count; n++) begin
            if (n % 160 == 159) begin
                drain_responses();
                write_reg(CFG_FACTOR, rand_word());
                write_reg(CFG_REFLECT, $urandom_range(0, 1));
            end
            case ($urandom_range(0, 19))
                0: fn = FN_CLEAR;
                1, 2, 3, 4, 5: fn = FN_INSERT;
                6, 7, 8, 9, 10, 11, 12: fn = FN_FORWARD;
                default: fn = FN_INVERSE;
            endcase
            send_request(fn, rand_word(), rand_word());
        end
        drain_responses();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        cyc = 0;
        err_cnt = 0;
        burst_left = 0;
        tbl_cnt = 0;
        gain = '0;
        mirror = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_table_edges();
        test_random(630);
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0 && rsp_queue.size() == 0) begin
            $display("[piecewise_linear_map_interp_unit] OK");
        end else begin
            $display("[piecewise_linear_map_interp_unit] ERROR");
        end
        $finish;
    end
endmodule

>>> piecewise_linear_map_interp_unit.f
hdl/plmi_pkg.sv
hdl/plmi_if.sv
hdl/plmi_cell.sv
hdl/plmi_muldiv.sv
hdl/piecewise_linear_map_interp_unit.sv
tb/piecewise_linear_map_interp_unit_tb.sv
